// ===== hdl/utf8s_pkg.sv =====
// shared types and constants for the utf8 sanitizer
// no dependencies
`default_nettype none

package utf8s_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CAP_W      = 9;
  localparam int unsigned BURST_MAX  = 4;
  localparam int unsigned BCNT_W     = 3;
  localparam int unsigned HELD_MAX   = 3;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 9'd33;
  localparam logic [BYTE_W-1:0] QMARK      = 8'h3F;
  localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
  localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;
  localparam logic [BYTE_W-1:0] MASK_E0    = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_F0    = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_F8    = 8'hF8;
  localparam logic [BYTE_W-1:0] MASK_C0    = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2      = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3      = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4      = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;

  // one input transaction turns into up to four output bytes
  typedef struct packed {
    logic [BURST_MAX-1:0][BYTE_W-1:0] bytes;
    logic [BCNT_W-1:0]                cnt;
    logic                             last;
  } burst_t;

endpackage

`default_nettype wire

// ===== hdl/utf8s_ifs.sv =====
// channel interfaces for the utf8 sanitizer
// depends on utf8s_pkg
`default_nettype none

interface utf8s_in_if import utf8s_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_string;
  modport source (output valid, in_byte, end_of_string, input ready);
  modport sink (input valid, in_byte, end_of_string, output ready);
endinterface

interface utf8s_out_if import utf8s_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;
  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

interface utf8s_cfg_if import utf8s_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] out_capacity;
  modport source (output valid, out_capacity, input ready);
  modport sink (input valid, out_capacity, output ready);
endinterface

`default_nettype wire

// ===== hdl/utf8s_front.sv =====
// front end: accepts bytes, tracks open sequences and capacity, builds bursts
// depends on utf8s_pkg and utf8s_ifs
`default_nettype none

module utf8s_front import utf8s_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  utf8s_in_if.sink   in_ch,
  utf8s_cfg_if.sink  cfg_ch,
  output burst_t     push_data,
  output logic       push_valid,
  input  logic       push_ready
);

  typedef struct packed {
    logic              emit;
    logic              lead;
    logic [1:0]        need;
    logic [BYTE_W-1:0] value;
  } fresh_t;

  function automatic fresh_t classify(input logic [BYTE_W-1:0] c);
    fresh_t f;
    f.emit  = 1'b0;
    f.lead  = 1'b0;
    f.need  = 2'd0;
    f.value = c;
    priority if (c < CTRL_LIMIT) begin
      f.emit  = 1'b1;
      f.value = QMARK;
    end else if (!c[BYTE_W-1]) begin
      f.emit = 1'b1;
    end else if ((c & MASK_E0) == LEAD2) begin
      f.lead = 1'b1;
      f.need = 2'd1;
    end else if ((c & MASK_F0) == LEAD3) begin
      f.lead = 1'b1;
      f.need = 2'd2;
    end else if ((c & MASK_F8) == LEAD4) begin
      f.lead = 1'b1;
      f.need = 2'd3;
    end else begin
      f.emit  = 1'b1;
      f.value = QMARK;
    end
    return f;
  endfunction

  logic [CAP_W-1:0]                  cap_r;
  logic [HELD_MAX-1:0][BYTE_W-1:0]   held_r, held_nxt;
  logic [1:0]                        hcnt_r, hcnt_nxt;
  logic [1:0]                        need_r, need_nxt;
  logic [CAP_W-1:0]                  wcnt_r, wcnt_nxt;

  logic                              accept;
  logic [BYTE_W-1:0]                 c;
  logic                              eos;
  logic                              is_cont;
  fresh_t                            fr;
  logic [BURST_MAX-1:0][BYTE_W-1:0]  raw;
  logic [BCNT_W-1:0]                 raw_k;
  logic [CAP_W+1:0]                  room;
  logic [BCNT_W-1:0]                 avail;
  logic [BCNT_W-1:0]                 dcnt;

  assign accept       = in_ch.valid && push_ready;
  assign in_ch.ready  = push_ready;
  assign cfg_ch.ready = 1'b1;
  assign c            = in_ch.in_byte;
  assign eos          = in_ch.end_of_string;
  assign is_cont      = (c & MASK_C0) == CONT_TAG;
  assign fr           = classify(c);

  // data bytes still allowed in this string, clamped to a burst
  always_comb begin
    room = {2'b00, cap_r} - {2'b00, wcnt_r} - (CAP_W+2)'(1);
    if (room[CAP_W+1])
      avail = '0;
    else if (room >= (CAP_W+2)'(BURST_MAX))
      avail = BCNT_W'(BURST_MAX);
    else
      avail = room[BCNT_W-1:0];
  end

  always_comb begin
    raw      = '0;
    raw_k    = '0;
    held_nxt = held_r;
    hcnt_nxt = hcnt_r;
    need_nxt = need_r;
    if (eos) begin
      raw_k    = {1'b0, hcnt_r};
      held_nxt = '0;
      hcnt_nxt = '0;
      need_nxt = '0;
    end else if (hcnt_r == 2'd0) begin
      raw[0] = fr.value;
      raw_k  = {2'b00, fr.emit};
      if (fr.lead) begin
        held_nxt    = '0;
        held_nxt[0] = c;
        hcnt_nxt    = 2'd1;
        need_nxt    = fr.need;
      end
    end else if (is_cont) begin
      if (hcnt_r >= need_r) begin
        for (int i = 0; i < BURST_MAX; i++) begin
          if (BCNT_W'(i) < {1'b0, hcnt_r})
            raw[i] = held_r[i % HELD_MAX];
          else
            raw[i] = c;
        end
        raw_k    = {1'b0, hcnt_r} + BCNT_W'(1);
        held_nxt = '0;
        hcnt_nxt = '0;
        need_nxt = '0;
      end else begin
        held_nxt[hcnt_r] = c;
        hcnt_nxt         = hcnt_r + 2'd1;
      end
    end else begin
      for (int i = 0; i < BURST_MAX; i++) begin
        if (BCNT_W'(i) < {1'b0, hcnt_r})
          raw[i] = QMARK;
        else
          raw[i] = fr.value;
      end
      raw_k    = {1'b0, hcnt_r} + {2'b00, fr.emit};
      held_nxt = '0;
      hcnt_nxt = '0;
      need_nxt = '0;
      if (fr.lead) begin
        held_nxt[0] = c;
        hcnt_nxt    = 2'd1;
        need_nxt    = fr.need;
      end
    end
  end

  always_comb begin
    dcnt = (raw_k < avail) ? raw_k : avail;
    push_data.bytes = raw;
    push_data.last  = eos;
    if (eos) begin
      for (int i = 0; i < BURST_MAX; i++)
        push_data.bytes[i] = (BCNT_W'(i) < dcnt) ? QMARK : NUL_BYTE;
      push_data.cnt = dcnt + BCNT_W'(1);
    end else begin
      push_data.cnt = dcnt;
    end
    push_valid = accept && (push_data.cnt != '0);
    wcnt_nxt   = eos ? '0 : wcnt_r + CAP_W'(dcnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      held_r <= '0;
      hcnt_r <= '0;
      need_r <= '0;
      wcnt_r <= '0;
    end else begin
      if (cfg_ch.valid)
        cap_r <= cfg_ch.out_capacity;
      if (accept) begin
        held_r <= held_nxt;
        hcnt_r <= hcnt_nxt;
        need_r <= need_nxt;
        wcnt_r <= wcnt_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/utf8s_fifo.sv =====
// short burst queue between front and back ends
// depends on utf8s_pkg
`default_nettype none

module utf8s_fifo import utf8s_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  input  burst_t push_data,
  output logic   push_ready,
  output logic   pop_valid,
  output burst_t pop_data,
  input  logic   pop
);

  burst_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr_r, rptr_r;
  logic [FIFO_CW-1:0]   cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign push_ready = cnt_r != FIFO_CW'(FIFO_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + FIFO_CW'(1);
      2'b01:   cnt_nxt = cnt_r - FIFO_CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push)
      mem_r[wptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push)
        wptr_r <= wptr_r + FIFO_AW'(1);
      if (do_pop)
        rptr_r <= rptr_r + FIFO_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/utf8s_back.sv =====
// back end: walks each queued burst one byte per cycle into an output register, holding while the output is stalled
// depends on utf8s_pkg and utf8s_ifs
`default_nettype none

module utf8s_back import utf8s_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  burst_t     head,
  output logic       pop,
  utf8s_out_if.source out_ch
);

  logic [1:0]        idx_r, idx_nxt;
  logic              vld_r;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;
  logic              load;
  logic              at_end;

  assign load   = head_valid && (!vld_r || out_ch.ready);
  assign at_end = (BCNT_W'(idx_r) + BCNT_W'(1)) == head.cnt;
  assign pop    = load && at_end;

  always_comb begin
    idx_nxt = idx_r;
    if (load)
      idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
  end

  assign out_ch.valid    = vld_r;
  assign out_ch.out_byte = byte_r;
  assign out_ch.last     = last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.bytes[idx_r];
      last_r <= head.last && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (load)
        vld_r <= 1'b1;
      else if (out_ch.ready)
        vld_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/utf8_sanitizer.sv =====
// top level of the utf8 sanitizer: front end, burst queue, back end
// depends on utf8s_pkg, utf8s_ifs, utf8s_front, utf8s_fifo, utf8s_back
//
//   channel  dir  payload                     transaction
//   in_ch    in   in_byte[7:0], end_of_string valid & ready
//   out_ch   out  out_byte[7:0], last         valid & ready
//   cfg_ch   in   out_capacity[8:0]           valid & ready (ready tied high)
//
// one input byte accepted per cycle while the burst queue has room
// each input byte makes 0..4 output bytes, drained at one per cycle by the back end while out_ch is not stalled
// the first output of an input transaction is registered in a queue entry and then in the back end output register
// synchronous active-low reset clears state and sets capacity to 33
// a stalled output fills the four-entry queue before the input stalls
`default_nettype none

module utf8_sanitizer import utf8s_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  utf8s_in_if.sink    in_ch,
  utf8s_out_if.source out_ch,
  utf8s_cfg_if.sink   cfg_ch
);

  burst_t push_data;
  logic   push_valid;
  logic   push_ready;
  burst_t head;
  logic   head_valid;
  logic   pop;

  utf8s_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  utf8s_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (head_valid),
    .pop_data   (head),
    .pop        (pop)
  );

  utf8s_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
